### src/cpg_pkg.sv
// cpg_pkg: shared types, widths and helpers for the circle point generator.
// Used by cpg_front, cpg_queue, cpg_back and circle_point_generator_core.
// No dependencies.
package cpg_pkg;

  // Radius width; offsets and decision term follow from it
  localparam int RADIUS_BITS = 10;
  localparam int RAD_IN_W    = 10;               // radius port width
  localparam int CENTER_W    = 10;               // center register width
  localparam int PIX_W       = 12;               // output coordinate width
  localparam int OFF_W       = RADIUS_BITS + 1;  // signed x / y offsets
  localparam int DEC_W       = RADIUS_BITS + 4;  // signed decision term
  localparam int SUM_W       = ((OFF_W > PIX_W) ? OFF_W : PIX_W) + 1;

  // Job queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Back end result sequencing: up to nine results per job
  localparam int CNT_W   = 4;
  localparam int PTS     = 8;

  // Action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;

  localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(260);
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(190);

  typedef enum logic [1:0] {
    JOB_START = 2'd0,  // center plus eight points
    JOB_STEP  = 2'd1,  // eight points
    JOB_DONE  = 2'd2   // single done result
  } job_kind_e;

  typedef struct packed {
    job_kind_e              kind;
    logic signed [OFF_W-1:0] x;
    logic signed [OFF_W-1:0] y;
  } job_t;

  // center +/- offset, wrapped to the output coordinate width
  function automatic logic [PIX_W-1:0] pix(input logic [CENTER_W-1:0] c,
                                           input logic signed [OFF_W-1:0] off,
                                           input logic neg);
    logic signed [SUM_W-1:0] cs;
    logic signed [SUM_W-1:0] os;
    logic signed [SUM_W-1:0] s;
    cs = $signed({{(SUM_W-CENTER_W){1'b0}}, c});
    os = SUM_W'(off);
    s  = neg ? (cs - os) : (cs + os);
    return s[PIX_W-1:0];
  endfunction

endpackage

### src/cpg_front.sv
// cpg_front: accepts input items, runs the midpoint decision step and
// issues one job per item. Depends on cpg_pkg.
module cpg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [cpg_pkg::RAD_IN_W-1:0] radius_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output cpg_pkg::job_t               q_job_o
);

  logic signed [cpg_pkg::OFF_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [cpg_pkg::DEC_W-1:0] dec_q, dec_d;
  logic                             active_q, active_d;

  logic [cpg_pkg::RADIUS_BITS+cpg_pkg::RAD_IN_W-1:0] rad_ext;
  logic [cpg_pkg::RADIUS_BITS-1:0]  rad;
  logic signed [cpg_pkg::OFF_W-1:0] x_inc, y_dec;
  logic signed [cpg_pkg::DEC_W-1:0] xe, ye, diff, dec_up, dec_st;
  logic                             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // radius masked / extended to RADIUS_BITS
  assign rad_ext = {{cpg_pkg::RADIUS_BITS{1'b0}}, radius_i};
  assign rad     = rad_ext[cpg_pkg::RADIUS_BITS-1:0];

  // decision update terms
  assign x_inc  = x_q + cpg_pkg::OFF_W'(1);
  assign y_dec  = y_q - cpg_pkg::OFF_W'(1);
  assign xe     = cpg_pkg::DEC_W'(x_inc);
  assign ye     = cpg_pkg::DEC_W'(y_dec);
  assign diff   = xe - ye;
  assign dec_up = (dec_q > 0) ? (dec_q + (diff <<< 2) + cpg_pkg::DEC_W'(10))
                              : (dec_q + (xe <<< 2) + cpg_pkg::DEC_W'(6));
  assign dec_st = cpg_pkg::DEC_W'(3) -
                  ({{(cpg_pkg::DEC_W-cpg_pkg::RADIUS_BITS){1'b0}}, rad} <<< 1);

  // next state and job
  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    active_d = active_q;
    q_job_o.kind = cpg_pkg::JOB_DONE;
    q_job_o.x    = x_q;
    q_job_o.y    = y_q;
    if (action_i == cpg_pkg::ACT_START) begin
      x_d      = '0;
      y_d      = $signed({1'b0, rad});
      dec_d    = dec_st;
      active_d = 1'b1;
      q_job_o.kind = cpg_pkg::JOB_START;
      q_job_o.x    = '0;
      q_job_o.y    = $signed({1'b0, rad});
    end else if (!active_q || (y_q < x_q)) begin
      active_d = 1'b0;
    end else begin
      x_d   = x_inc;
      dec_d = dec_up;
      if (dec_q > 0) begin
        y_d = y_dec;
      end
      q_job_o.kind = cpg_pkg::JOB_STEP;
      q_job_o.x    = x_inc;
      q_job_o.y    = (dec_q > 0) ? y_dec : y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

endmodule

### src/cpg_queue.sv
// cpg_queue: short FIFO of jobs between front and back.
// Depends on cpg_pkg.
module cpg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpg_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cpg_pkg::job_t head_o
);

  cpg_pkg::job_t                mem_q [cpg_pkg::QDEPTH];
  logic [cpg_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [cpg_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == cpg_pkg::QCNT_W'(cpg_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // pointer wrap at the queue depth
  function automatic logic [cpg_pkg::QPTR_W-1:0] nxt(input logic [cpg_pkg::QPTR_W-1:0] p);
    return (p == cpg_pkg::QPTR_W'(cpg_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/cpg_back.sv
// cpg_back: expands a job into its result stream, one result per cycle while
// the receiver does not stall, through an output register. Depends on cpg_pkg.
module cpg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  cpg_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  input  logic [cpg_pkg::CENTER_W-1:0]  center_x_i,
  input  logic [cpg_pkg::CENTER_W-1:0]  center_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [cpg_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [cpg_pkg::PIX_W-1:0] pixel_y_o,
  output logic                          pixel_valid_o,
  output logic                          done_res_o,
  output logic                          last_o
);

  logic [cpg_pkg::CNT_W-1:0]        cnt_q;
  logic                             ovalid_q;
  logic [cpg_pkg::PIX_W-1:0]        px_q, py_q, px_d, py_d;
  logic                             pv_q, dn_q, ls_q, pv_d, dn_d, ls_d;
  logic                             adv;
  logic [cpg_pkg::CNT_W-1:0]        pnum;
  logic [2:0]                       p;
  logic signed [cpg_pkg::OFF_W-1:0] a, b;

  assign adv       = job_valid_i && (!ovalid_q || !out_stall_i);
  assign job_pop_o = adv && ls_d;

  // point number within the eight-way pattern
  assign pnum = (job_i.kind == cpg_pkg::JOB_START) ? (cnt_q - 1'b1) : cnt_q;
  assign p    = pnum[2:0];
  assign a    = p[2] ? job_i.y : job_i.x;
  assign b    = p[2] ? job_i.x : job_i.y;

  // next result
  always_comb begin
    px_d = cpg_pkg::pix(center_x_i, a, p[0]);
    py_d = cpg_pkg::pix(center_y_i, b, p[1]);
    pv_d = 1'b1;
    dn_d = 1'b0;
    ls_d = 1'b0;
    unique case (job_i.kind)
      cpg_pkg::JOB_START: begin
        if (cnt_q == '0) begin
          px_d = cpg_pkg::pix(center_x_i, '0, 1'b0);
          py_d = cpg_pkg::pix(center_y_i, '0, 1'b0);
        end
        ls_d = (cnt_q == cpg_pkg::CNT_W'(cpg_pkg::PTS));
      end
      cpg_pkg::JOB_STEP: begin
        ls_d = (cnt_q == cpg_pkg::CNT_W'(cpg_pkg::PTS - 1));
      end
      default: begin
        px_d = '0;
        py_d = '0;
        pv_d = 1'b0;
        dn_d = 1'b1;
        ls_d = 1'b1;
      end
    endcase
  end

  // sequence counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (adv) begin
        cnt_q <= ls_d ? '0 : cnt_q + 1'b1;
      end
      if (adv) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= px_d;
      py_q <= py_d;
      pv_q <= pv_d;
      dn_q <= dn_d;
      ls_q <= ls_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign pixel_x_o     = $signed(px_q);
  assign pixel_y_o     = $signed(py_q);
  assign pixel_valid_o = pv_q;
  assign done_res_o    = dn_q;
  assign last_o        = ls_q;

endmodule

### src/circle_point_generator_core.sv
// Midpoint circle rasterizer stepped by input items: a start item (action 0)
// emits the center and the eight symmetric points of (0, r); each advance
// item (action 1) takes one midpoint step and emits eight points, or a single
// done result once the octant is finished. Results leave one per cycle unless
// the receiver stalls: a step item gives 8 results, a start item 9 and a done
// item 1; the rate is set by the result register in the back end. The front
// end updates the decision state per accepted item and can run up to two jobs
// ahead through the job queue. Coordinates wrap to 12 bits and are not clipped.
// Depends on cpg_pkg, cpg_front, cpg_queue and cpg_back.
module circle_point_generator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [cpg_pkg::CENTER_W-1:0]   cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [cpg_pkg::RAD_IN_W-1:0]   radius_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [cpg_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [cpg_pkg::PIX_W-1:0] pixel_y_o,
  output logic                           pixel_valid_o,
  output logic                           done_res_o,
  output logic                           last_o
);

  logic [cpg_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic                         q_full, q_push, q_valid, q_pop;
  cpg_pkg::job_t                push_job, head_job;

  // center registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= cpg_pkg::CENTER_X_RST;
      center_y_q <= cpg_pkg::CENTER_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpg_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
        cpg_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .radius_i   (radius_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  cpg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  cpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .job_pop_o     (q_pop),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .done_res_o    (done_res_o),
    .last_o        (last_o)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for circle_point_generator_core: drives start and
// advance items, predicts every pixel and done result, checks them in order.
// Depends on cpg_pkg and the circle_point_generator_core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 130;
  localparam int SETTLE_CYCLES = 12;    // extra wait once every owed result has been seen
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [cpg_pkg::PIX_W-1:0] px;
    logic [cpg_pkg::PIX_W-1:0] py;
    logic                      pv;
    logic                      dn;
    logic                      lst;
  } pixel_t;

  typedef enum logic [1:0] {
    RECV_FREE,
    RECV_RANDOM,
    RECV_PATTERN
  } recv_mode_e;

  // DUT signals
  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic                             cfg_idx_i;
  logic [cpg_pkg::CENTER_W-1:0]     cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             action_i;
  logic [cpg_pkg::RAD_IN_W-1:0]     radius_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [cpg_pkg::PIX_W-1:0] pixel_x_o;
  logic signed [cpg_pkg::PIX_W-1:0] pixel_y_o;
  logic                             pixel_valid_o;
  logic                             done_res_o;
  logic                             last_o;

  // Rasterizer mirror: center registers and midpoint state
  logic [cpg_pkg::CENTER_W-1:0]     ctr_x = cpg_pkg::CENTER_X_RST;
  logic [cpg_pkg::CENTER_W-1:0]     ctr_y = cpg_pkg::CENTER_Y_RST;
  logic signed [cpg_pkg::OFF_W-1:0] ras_x = '0;
  logic signed [cpg_pkg::OFF_W-1:0] ras_y = '0;
  logic signed [cpg_pkg::DEC_W-1:0] ras_d = '0;
  logic                             ras_active = 1'b0;

  pixel_t pixel_q[$];  // pixels and done results still owed by the block

  // Run bookkeeping
  int errors        = 0;
  int results_seen  = 0;
  int done_seen     = 0;
  int starts_sent   = 0;
  int advances_sent = 0;
  int settings_made = 0;
  int in_stall_cyc  = 0;
  int quiet_cyc     = 0;

  // Stimulus pacing
  int         burst_left = 0;
  bit         pace_on    = 1'b1;
  recv_mode_e recv_mode  = RECV_FREE;
  int         hold_left  = 0;
  logic [6:0] stall_pat  = 7'b0010110;

  circle_point_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .radius_i      (radius_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .done_res_o    (done_res_o),
    .last_o        (last_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // center +/- offset, wrapped to the pixel width
  function automatic logic [cpg_pkg::PIX_W-1:0] offset_coord(
      input logic [cpg_pkg::CENTER_W-1:0] c,
      input logic signed [cpg_pkg::OFF_W-1:0] off,
      input bit neg);
    int s;
    s = neg ? int'(c) - int'(off) : int'(c) + int'(off);
    return s[cpg_pkg::PIX_W-1:0];
  endfunction

  // Eight octant mirrors of the current (x, y), last flag on the eighth
  function automatic void emit_octants();
    pixel_t p;
    for (int i = 0; i < 8; i++) begin
      p.px  = offset_coord(ctr_x, (i < 4) ? ras_x : ras_y, i[0]);
      p.py  = offset_coord(ctr_y, (i < 4) ? ras_y : ras_x, i[1]);
      p.pv  = 1'b1;
      p.dn  = 1'b0;
      p.lst = (i == 7);
      pixel_q.push_back(p);
    end
  endfunction

  // One midpoint step per accepted item
  function automatic void rasterize(input logic act,
                                    input logic [cpg_pkg::RAD_IN_W-1:0] rad);
    pixel_t p;
    int     r;
    r = int'(rad) & ((1 << cpg_pkg::RADIUS_BITS) - 1);
    if (act == cpg_pkg::ACT_START) begin
      ras_x      = '0;
      ras_y      = cpg_pkg::OFF_W'(r);
      ras_d      = cpg_pkg::DEC_W'(3 - 2 * r);
      ras_active = 1'b1;
      p = '{px: offset_coord(ctr_x, '0, 1'b0), py: offset_coord(ctr_y, '0, 1'b0),
            pv: 1'b1, dn: 1'b0, lst: 1'b0};
      pixel_q.push_back(p);
      emit_octants();
    end else if (!ras_active || ras_y < ras_x) begin
      ras_active = 1'b0;
      p = '{px: '0, py: '0, pv: 1'b0, dn: 1'b1, lst: 1'b1};
      pixel_q.push_back(p);
    end else begin
      ras_x = ras_x + cpg_pkg::OFF_W'(1);
      if (ras_d > 0) begin
        ras_y = ras_y - cpg_pkg::OFF_W'(1);
        ras_d = cpg_pkg::DEC_W'(ras_d + 4 * (ras_x - ras_y) + 10);
      end else begin
        ras_d = cpg_pkg::DEC_W'(ras_d + 4 * ras_x + 6);
      end
      emit_octants();
    end
  endfunction

  task automatic log_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%t ERROR: %s", $realtime, msg);
  endtask

  // Monitor: config writes, accepted items and result checks at the rising edge
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cpg_pkg::CFG_CENTER_X) ctr_x = cfg_data_i;
        else ctr_y = cfg_data_i;
      end
      if (in_valid_i && in_stall_o) in_stall_cyc++;
      if (in_valid_i && !in_stall_o) rasterize(action_i, radius_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pixel_q.size() == 0) begin
          log_failure($sformatf("unexpected result x=%0d y=%0d pv=%b done=%b last=%b",
                                pixel_x_o, pixel_y_o, pixel_valid_o, done_res_o, last_o));
        end else begin
          want = pixel_q.pop_front();
          if (want.dn) done_seen++;
          if (pixel_x_o !== want.px || pixel_y_o !== want.py ||
              pixel_valid_o !== want.pv || done_res_o !== want.dn || last_o !== want.lst)
            log_failure($sformatf(
              "exp x=%0d y=%0d pv=%b done=%b last=%b, got x=%0d y=%0d pv=%b done=%b last=%b",
              $signed(want.px), $signed(want.py), want.pv, want.dn, want.lst,
              pixel_x_o, pixel_y_o, pixel_valid_o, done_res_o, last_o));
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i) && !cfg_we_i)
      quiet_cyc++;
    else
      quiet_cyc = 0;
    if (quiet_cyc == QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cyc, pixel_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // Result receiver: long hold-off first, otherwise stalls per current mode
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall_pat = {stall_pat[0], stall_pat[6:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (recv_mode)
          RECV_FREE:    out_stall_i <= 1'b0;
          RECV_RANDOM:  out_stall_i <= ($urandom_range(0, 2) == 0);
          default:      out_stall_i <= stall_pat[0];
        endcase
      end
    end
  end

  // Offer one item, in bursts with random gaps, and wait for its transfer
  task automatic send_item(input logic act, input logic [cpg_pkg::RAD_IN_W-1:0] rad);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = pace_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    radius_i   <= rad;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (act == cpg_pkg::ACT_START) starts_sent++;
    else advances_sent++;
  endtask

  // Stop offering and let every owed result come out
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Move the circle center; only done with the block idle
  task automatic set_center(input logic [cpg_pkg::CENTER_W-1:0] cx,
                            input logic [cpg_pkg::CENTER_W-1:0] cy);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cpg_pkg::CFG_CENTER_X;
    cfg_data_i <= cx;
    @(negedge clk_i);
    cfg_idx_i  <= cpg_pkg::CFG_CENTER_Y;
    cfg_data_i <= cy;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_made++;
  endtask

  // Advance before any start, then a zero radius circle run past its end
  task automatic test_idle_and_zero_radius();
    recv_mode = RECV_PATTERN;
    send_item(cpg_pkg::ACT_ADVANCE, '1);
    send_item(cpg_pkg::ACT_START, '0);
    send_item(cpg_pkg::ACT_ADVANCE, '0);
    send_item(cpg_pkg::ACT_ADVANCE, '0);
    send_item(cpg_pkg::ACT_ADVANCE, '0);
  endtask

  // Largest radius at both corner centers, restart mid-circle, radius one to done
  task automatic test_extreme_centers();
    recv_mode = RECV_RANDOM;
    set_center('0, '0);
    send_item(cpg_pkg::ACT_START, '1);
    send_item(cpg_pkg::ACT_ADVANCE, '0);
    send_item(cpg_pkg::ACT_ADVANCE, '1);
    set_center('1, '1);
    send_item(cpg_pkg::ACT_START, '1);
    send_item(cpg_pkg::ACT_ADVANCE, '0);
    send_item(cpg_pkg::ACT_START, cpg_pkg::RAD_IN_W'(1));
    repeat (3) send_item(cpg_pkg::ACT_ADVANCE, cpg_pkg::RAD_IN_W'(10'h2aa));
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_center(cpg_pkg::CENTER_X_RST, cpg_pkg::CENTER_Y_RST);
    pace_on   = 1'b0;
    recv_mode = RECV_FREE;
    hold_left = HOLD_CYCLES;
    send_item(cpg_pkg::ACT_START, cpg_pkg::RAD_IN_W'(20));
    repeat (12) send_item(cpg_pkg::ACT_ADVANCE, cpg_pkg::RAD_IN_W'(10'h155));
    wait_idle();
    pace_on = 1'b1;
  endtask

  // Circles with random radius and length, some stray items
  task automatic test_random_circles();
    int n;
    int next_cfg;
    int r;
    int full;
    int k;
    n = 0;
    next_cfg = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= next_cfg) begin
        set_center(cpg_pkg::CENTER_W'($urandom_range(0, 1023)),
                   cpg_pkg::CENTER_W'($urandom_range(0, 1023)));
        next_cfg = n + 40;
      end
      recv_mode = recv_mode_e'($urandom_range(0, 2));
      pace_on   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: r = $urandom_range(0, 24);
          6, 7, 8:          r = $urandom_range(0, 1023);
          default:          r = $urandom_range(1000, 1023);
        endcase
        // steps to finish the octant, capped at 24, plus a stray advance or two
        full = (r * 71) / 100 + 3;
        if (full > 24) full = 24;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, full) : full;
        send_item(cpg_pkg::ACT_START, cpg_pkg::RAD_IN_W'(r));
        repeat (k) send_item(cpg_pkg::ACT_ADVANCE,
                             cpg_pkg::RAD_IN_W'($urandom_range(0, 1023)));
        n += k + 1;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) send_item(logic'($urandom_range(0, 1)),
                             cpg_pkg::RAD_IN_W'($urandom_range(0, 1023)));
        n += k;
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = cpg_pkg::CFG_CENTER_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i   = cpg_pkg::ACT_START;
    radius_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_zero_radius();
    test_extreme_centers();
    test_output_backpressure();
    test_random_circles();
    wait_idle();

    if (pixel_q.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", pixel_q.size()));
    $display("run covered %0d starts and %0d advances, %0d results checked (%0d done)",
             starts_sent, advances_sent, results_seen, done_seen);
    $display("  across %0d center settings, %0d input stall cycles, %0d mismatches",
             settings_made, in_stall_cyc, errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/cpg_pkg.sv
src/cpg_front.sv
src/cpg_queue.sv
src/cpg_back.sv
src/circle_point_generator_core.sv
tb/sv/testbench.sv
